// ===== rtl/tspt_pkg.sv =====
// Shared constants, types and field offsets for the two-axis step pulse timer.
// Used by tspt_div, tspt_axis, two_axis_step_pulse_timer_core and the testbench; depends on nothing.
package tspt_pkg;

  localparam int unsigned TIME_BITS = 16;
  localparam int unsigned STEP_BITS = 16;
  localparam int unsigned WIDE_BITS = TIME_BITS + 1;
  localparam int unsigned CNT_W     = $clog2(WIDE_BITS);

  // Input tdata layout, lowest bit first.
  localparam int unsigned TB_OFS     = TIME_BITS;
  localparam int unsigned TBACK_OFS  = TIME_BITS + STEP_BITS;
  localparam int unsigned RS_OFS     = TIME_BITS + STEP_BITS + 1;
  localparam int unsigned RBACK_OFS  = TIME_BITS + 2 * STEP_BITS + 1;
  localparam int unsigned IN_BITS    = TIME_BITS + 2 * STEP_BITS + 2;
  localparam int unsigned IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_BITS   = 4;
  localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_TICK,
    S_FIN
  } state_e;

  typedef enum logic [1:0] {
    K_START,
    K_TICK,
    K_NOP
  } kind_e;

  typedef struct packed {
    logic load;       // start transfer: load steps, direction, divider
    logic div_step;   // one quotient bit
    logic tick_step;  // one time bit through the serial compare and add
    logic per_load;   // take the finished quotient as the interval
    logic commit;     // apply the pulse decision of a tick
    logic end_move;   // drop all steps not yet issued
  } axis_ctl_t;

  typedef struct packed {
    logic pulse;
    logic dir;
  } axis_res_t;

endpackage

// ===== rtl/two_axis_step_pulse_timer_core.sv =====
// Top level of the two-axis step pulse timer: stream ports, sequencer, elapsed-time
// and duration shift registers, result register. Depends on tspt_pkg and tspt_axis.
//
//   channel  dir  handshake                     contents
//   s_axis   in   s_axis_tvalid/s_axis_tready   tdata: move and step counts, tuser: op
//   m_axis   out  m_axis_tvalid/m_axis_tready   tdata: pulses and directions, tlast: done
//
// A start transfer runs the serial divider, one quotient bit per cycle. A tick during a move
// passes the 17-bit time words one bit per cycle through the serial compares and adders.
// A tick while idle goes straight to the final state.
// Reset leaves the block idle with no move. A stalled result waits in the output register
// while the next transfer is taken; that item then holds in its final state until the
// output register frees.
module two_axis_step_pulse_timer_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // tdata: move_time, theta_steps, theta_backward, rho_steps, rho_backward, zero pad
  input  logic [tspt_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // tuser: op
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // tdata: theta_pulse, theta_dir_out, rho_pulse, rho_dir_out, zero pad
  output logic [tspt_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // tlast: move_done
  output logic                             m_axis_tlast
);
  import tspt_pkg::*;

  state_e               state_q, state_d;
  kind_e                kind_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 active_q;
  logic [WIDE_BITS-1:0] el_q, dur_q;
  logic                 brw_q, cry_q;
  logic                 m_valid_q;
  logic [OUT_BITS-1:0]  m_data_q;
  logic                 m_last_q;

  logic                 s_xfer;
  logic                 out_free;
  logic                 out_load;
  logic                 is_start;
  logic                 reached;
  logic                 e_bit, u_bit;
  axis_ctl_t            ctl;
  axis_res_t            th_res, rh_res;
  logic [TIME_BITS-1:0] in_time;

  assign in_time  = s_axis_tdata[TIME_BITS-1:0];
  assign s_xfer   = s_axis_tvalid && s_axis_tready;
  assign is_start = (s_axis_tuser == OP_START);
  assign out_free = !m_valid_q || m_axis_tready;
  assign e_bit    = el_q[0];
  assign u_bit    = dur_q[0];
  assign reached  = !brw_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_xfer) begin
          if (is_start) state_d = S_DIV;
          else if (active_q) state_d = S_TICK;
          else state_d = S_FIN;
        end
      end
      S_DIV, S_TICK: begin
        if (cnt_q == '0) state_d = S_FIN;
      end
      S_FIN: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    ctl           = '0;
    unique case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        ctl.load      = s_xfer && is_start;
      end
      S_DIV:  ctl.div_step = 1'b1;
      S_TICK: ctl.tick_step = 1'b1;
      S_FIN: begin
        out_load     = out_free;
        ctl.per_load = out_free && (kind_q == K_START);
        ctl.commit   = out_free && (kind_q == K_TICK);
        ctl.end_move = out_free && (((kind_q == K_TICK) && reached) ||
                                    ((kind_q == K_START) && (dur_q == '0)));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      kind_q    <= K_NOP;
      cnt_q     <= '0;
      active_q  <= 1'b0;
      brw_q     <= 1'b0;
      cry_q     <= 1'b1;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_IDLE && s_xfer) begin
        if (is_start) begin
          kind_q <= K_START;
          cnt_q  <= CNT_W'(TIME_BITS - 1);
        end else begin
          kind_q <= active_q ? K_TICK : K_NOP;
          cnt_q  <= CNT_W'(WIDE_BITS - 1);
        end
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
      end
      if (ctl.tick_step) begin
        brw_q <= (~e_bit & u_bit) | (~(e_bit ^ u_bit) & brw_q);
        cry_q <= e_bit & cry_q;
      end else if (out_load) begin
        brw_q <= 1'b0;
        cry_q <= 1'b1;
      end
      // A new move only goes live once its intervals are in place.
      if (ctl.load) begin
        active_q <= 1'b0;
      end else if (ctl.per_load) begin
        active_q <= (dur_q != '0);
      end else if (ctl.commit && reached) begin
        active_q <= 1'b0;
      end
      if (out_load) m_valid_q <= 1'b1;
      else if (m_axis_tready) m_valid_q <= 1'b0;
    end
  end

  // Elapsed time counts up by one per tick through a serial incrementer.
  always_ff @(posedge clk_i) begin
    if (ctl.load) begin
      el_q  <= '0;
      dur_q <= {1'b0, in_time};
    end else if (ctl.tick_step) begin
      el_q  <= {e_bit ^ cry_q, el_q[WIDE_BITS-1:1]};
      dur_q <= {u_bit, dur_q[WIDE_BITS-1:1]};
    end
    if (out_load) begin
      if (kind_q == K_TICK) begin
        m_data_q <= {rh_res.dir, rh_res.pulse, th_res.dir, th_res.pulse};
        m_last_q <= reached;
      end else begin
        m_data_q <= '0;
        m_last_q <= (kind_q == K_START) && (dur_q == '0);
      end
    end
  end

  tspt_axis u_theta (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .dur_i   ((ctl.load ? in_time : dur_q[TIME_BITS-1:0])),
    .steps_i (s_axis_tdata[TB_OFS +: STEP_BITS]),
    .back_i  (s_axis_tdata[TBACK_OFS]),
    .t_bit_i (e_bit),
    .res_o   (th_res)
  );

  tspt_axis u_rho (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .dur_i   ((ctl.load ? in_time : dur_q[TIME_BITS-1:0])),
    .steps_i (s_axis_tdata[RS_OFS +: STEP_BITS]),
    .back_i  (s_axis_tdata[RBACK_OFS]),
    .t_bit_i (e_bit),
    .res_o   (rh_res)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - OUT_BITS){1'b0}}, m_data_q};
  assign m_axis_tlast  = m_last_q;

`ifndef ASSERT_OFF
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (!m_axis_tlast || !active_q))
    else $error("move_done reported while a move is still active");

  a_dir_needs_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata[0] || !m_axis_tdata[1]) &&
                       (m_axis_tdata[2] || !m_axis_tdata[3])))
    else $error("direction set without a pulse");

  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer |=> !s_axis_tready)
    else $error("input ready right after a transfer");

  a_active_dur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (dur_q != '0))
    else $error("active move with zero duration");

  a_tick_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TICK) |-> active_q)
    else $error("serial tick pass without an active move");
`endif

endmodule

// ===== rtl/tspt_div.sv =====
// Bit-serial restoring divider: one quotient bit per step, MSB first.
// Uses widths from tspt_pkg; instantiated once per axis by tspt_axis.
module tspt_div (
  input  logic                            clk_i,
  input  logic                            load_i,
  input  logic                            step_i,
  input  logic [tspt_pkg::TIME_BITS-1:0]  dividend_i,
  input  logic [tspt_pkg::STEP_BITS-1:0]  divisor_i,
  output logic [tspt_pkg::TIME_BITS-1:0]  quot_o
);
  import tspt_pkg::*;

  logic [STEP_BITS-1:0] rem_q, rem_d;
  logic [TIME_BITS-1:0] quo_q, quo_d;
  logic [STEP_BITS-1:0] dvs_q;
  logic [STEP_BITS:0]   trial;
  logic [STEP_BITS:0]   diff;
  logic                 fits;

  always_comb begin
    trial = {rem_q, quo_q[TIME_BITS-1]};
    diff  = trial - {1'b0, dvs_q};
    fits  = trial >= {1'b0, dvs_q};
    rem_d = fits ? diff[STEP_BITS-1:0] : trial[STEP_BITS-1:0];
    quo_d = {quo_q[TIME_BITS-2:0], fits};
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (step_i) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign quot_o = quo_q;

endmodule

// ===== rtl/tspt_axis.sv =====
// One axis: step count, direction, interval and due time, with a bit-serial
// compare of elapsed time against the due time and a serial add of the interval.
// Depends on tspt_pkg and tspt_div.
module tspt_axis (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  tspt_pkg::axis_ctl_t             ctl_i,
  input  logic [tspt_pkg::TIME_BITS-1:0]  dur_i,
  input  logic [tspt_pkg::STEP_BITS-1:0]  steps_i,
  input  logic                            back_i,
  input  logic                            t_bit_i,
  output tspt_pkg::axis_res_t             res_o
);
  import tspt_pkg::*;

  logic [STEP_BITS-1:0] left_q;
  logic                 back_q;
  logic                 zero_q;
  logic                 brw_q, cry_q;
  logic [WIDE_BITS-1:0] due_q, per_q, sum_q;
  logic [TIME_BITS-1:0] quot;
  logic                 d_bit, p_bit, s_bit, cry_d, brw_d;
  logic                 pulse;

  tspt_div u_div (
    .clk_i      (clk_i),
    .load_i     (ctl_i.load),
    .step_i     (ctl_i.div_step),
    .dividend_i (dur_i),
    .divisor_i  (steps_i),
    .quot_o     (quot)
  );

  always_comb begin
    d_bit = due_q[0];
    p_bit = per_q[0];
    s_bit = d_bit ^ p_bit ^ cry_q;
    cry_d = (d_bit & p_bit) | (cry_q & (d_bit ^ p_bit));
    // Borrow of elapsed minus due, LSB first; no final borrow means due has been reached.
    brw_d = (~t_bit_i & d_bit) | (~(t_bit_i ^ d_bit) & brw_q);
    pulse = (left_q != '0) && !brw_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
      back_q <= 1'b0;
      zero_q <= 1'b0;
      brw_q  <= 1'b0;
      cry_q  <= 1'b0;
    end else begin
      if (ctl_i.load) begin
        left_q <= steps_i;
        back_q <= back_i;
        zero_q <= (steps_i == '0);
        brw_q  <= 1'b0;
        cry_q  <= 1'b0;
      end else if (ctl_i.tick_step) begin
        brw_q <= brw_d;
        cry_q <= cry_d;
      end else if (ctl_i.commit || ctl_i.per_load) begin
        brw_q <= 1'b0;
        cry_q <= 1'b0;
      end
      if (ctl_i.end_move) begin
        left_q <= '0;
      end else if (ctl_i.commit && pulse) begin
        left_q <= left_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      due_q <= '0;
    end else if (ctl_i.tick_step) begin
      due_q <= {d_bit, due_q[WIDE_BITS-1:1]};
      per_q <= {p_bit, per_q[WIDE_BITS-1:1]};
      sum_q <= {s_bit, sum_q[WIDE_BITS-1:1]};
    end else if (ctl_i.commit && pulse) begin
      due_q <= sum_q;
    end
    if (ctl_i.per_load) begin
      per_q <= {1'b0, (zero_q ? dur_i : quot)};
    end
  end

  assign res_o.pulse = pulse;
  assign res_o.dir   = pulse & back_q;

endmodule

// ===== dv/tb_two_axis_step_pulse_timer_core.sv =====
// Testbench for two_axis_step_pulse_timer_core: directed, then random stream traffic
// on both sides, with a scoreboard class that predicts every result and checks it in order.
// Depends on tspt_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_two_axis_step_pulse_timer_core;
  import tspt_pkg::*;

  localparam int unsigned AXES           = 2;
  localparam int unsigned AX_THETA       = 0;
  localparam int unsigned AX_RHO         = 1;
  localparam int unsigned LIVE_ITEMS     = 1400;
  localparam int unsigned MAX_GAP        = 13;
  localparam int unsigned SETTLE_CYCLES  = 40;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned MAX_REPORTS    = 10;

  typedef struct packed {
    logic theta_pulse;
    logic theta_dir;
    logic rho_pulse;
    logic rho_dir;
    logic done;
  } poll_result_t;

  class pulse_scoreboard;
    bit                   running;
    logic [WIDE_BITS-1:0] elapsed_ms;
    logic [TIME_BITS-1:0] move_ms;
    logic [WIDE_BITS-1:0] due [AXES];
    logic [TIME_BITS-1:0] interval [AXES];
    logic [STEP_BITS-1:0] steps_left [AXES];
    logic                 backward [AXES];
    poll_result_t         pending_polls [$];
    int unsigned          mismatches;
    int unsigned          checked;

    function new();
      running    = 1'b0;
      elapsed_ms = '0;
      move_ms    = '0;
      for (int a = 0; a < AXES; a++) begin
        due[a]        = '0;
        interval[a]   = '0;
        steps_left[a] = '0;
        backward[a]   = 1'b0;
      end
      mismatches = 0;
      checked    = 0;
    endfunction

    function int unsigned outstanding();
      return pending_polls.size();
    endfunction

    // Works out the result of one accepted input transfer and queues it.
    function void note_item(logic op, logic [IN_DATA_W-1:0] d);
      poll_result_t         res;
      logic [STEP_BITS-1:0] steps [AXES];
      logic                 dir_in [AXES];
      logic                 pulse [AXES];
      logic                 pdir [AXES];
      res = '0;
      steps[AX_THETA]  = d[TB_OFS +: STEP_BITS];
      steps[AX_RHO]    = d[RS_OFS +: STEP_BITS];
      dir_in[AX_THETA] = d[TBACK_OFS];
      dir_in[AX_RHO]   = d[RBACK_OFS];
      for (int a = 0; a < AXES; a++) begin
        pulse[a] = 1'b0;
        pdir[a]  = 1'b0;
      end
      if (op == OP_START) begin
        move_ms    = d[TIME_BITS-1:0];
        elapsed_ms = '0;
        for (int a = 0; a < AXES; a++) begin
          backward[a]   = dir_in[a];
          interval[a]   = (steps[a] == 0) ? move_ms : TIME_BITS'(move_ms / steps[a]);
          due[a]        = '0;
          steps_left[a] = (move_ms == 0) ? '0 : steps[a];
        end
        running  = (move_ms != 0);
        res.done = (move_ms == 0);
      end else if (running) begin
        for (int a = 0; a < AXES; a++) begin
          if (steps_left[a] != 0 && elapsed_ms >= due[a]) begin
            pulse[a]      = 1'b1;
            pdir[a]       = backward[a];
            steps_left[a] = steps_left[a] - 1'b1;
            due[a]        = due[a] + WIDE_BITS'(interval[a]);
          end
        end
        // The poll that reaches the duration still issues due steps, then ends the move.
        if (elapsed_ms >= {1'b0, move_ms}) begin
          running = 1'b0;
          for (int a = 0; a < AXES; a++) steps_left[a] = '0;
          res.done = 1'b1;
        end else begin
          elapsed_ms = elapsed_ms + 1'b1;
        end
      end
      res.theta_pulse = pulse[AX_THETA];
      res.theta_dir   = pdir[AX_THETA];
      res.rho_pulse   = pulse[AX_RHO];
      res.rho_dir     = pdir[AX_RHO];
      pending_polls.push_back(res);
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data, logic last);
      poll_result_t got;
      poll_result_t want;
      got.theta_pulse = data[0];
      got.theta_dir   = data[1];
      got.rho_pulse   = data[2];
      got.rho_dir     = data[3];
      got.done        = last;
      checked++;
      if (pending_polls.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result transfer: tdata=%b tlast=%b", data, last);
        return;
      end
      want = pending_polls.pop_front();
      if (got.theta_pulse !== want.theta_pulse || got.theta_dir !== want.theta_dir ||
          got.rho_pulse !== want.rho_pulse || got.rho_dir !== want.rho_dir ||
          got.done !== want.done) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $write("result %0d mismatch: expected tp=%b td=%b rp=%b rd=%b done=%b,",
                 checked, want.theta_pulse, want.theta_dir, want.rho_pulse,
                 want.rho_dir, want.done);
          $display(" got tp=%b td=%b rp=%b rd=%b done=%b",
                   got.theta_pulse, got.theta_dir, got.rho_pulse, got.rho_dir,
                   got.done);
        end
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;

  pulse_scoreboard board = new();
  bit              quiet;
  int unsigned     n_live;
  int unsigned     n_starts;
  int unsigned     n_ticks;
  int unsigned     n_moves_done;

  two_axis_step_pulse_timer_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [IN_DATA_W-1:0] pack_move(logic [TIME_BITS-1:0] dur,
                                                     logic [STEP_BITS-1:0] ts, logic tb,
                                                     logic [STEP_BITS-1:0] rs, logic rb);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[TIME_BITS-1:0]        = dur;
    d[TB_OFS +: STEP_BITS]  = ts;
    d[TBACK_OFS]            = tb;
    d[RS_OFS +: STEP_BITS]  = rs;
    d[RBACK_OFS]            = rb;
    return d;
  endfunction

  // Tick transfers carry random move fields, which the block must ignore.
  function automatic logic [IN_DATA_W-1:0] tick_noise();
    return pack_move(TIME_BITS'($urandom), STEP_BITS'($urandom), 1'($urandom),
                     STEP_BITS'($urandom), 1'($urandom));
  endfunction

  function automatic logic [STEP_BITS-1:0] pick_steps(int unsigned dur);
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0:       return '0;
      1, 2:    return STEP_BITS'($urandom);
      3:       return '1;
      default: return STEP_BITS'($urandom_range(1, dur + 3));
    endcase
  endfunction

  task automatic send_item(input logic op, input logic [IN_DATA_W-1:0] data);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    if (op == OP_START || board.running) n_live++;
    if (op == OP_START) n_starts++;
    else n_ticks++;
    board.note_item(op, data);
    if (board.pending_polls.size() != 0 && board.pending_polls[$].done) n_moves_done++;
  endtask

  task automatic run_move(input logic [TIME_BITS-1:0] dur, input logic [STEP_BITS-1:0] ts,
                          input logic tb, input logic [STEP_BITS-1:0] rs, input logic rb,
                          input int unsigned polls);
    send_item(OP_START, pack_move(dur, ts, tb, rs, rb));
    repeat (polls) send_item(OP_TICK, tick_noise());
  endtask

  // The last transfer is already taken, so the input goes quiet while results drain.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk_i);
  endtask

  // Result side: random stalls before each transfer, none during quiet stretches.
  initial begin
    int unsigned gap;
    m_axis_tready = 1'b0;
    wait (rst_ni);
    forever begin
      gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      board.check_result(m_axis_tdata, m_axis_tlast);
    end
  end

  initial begin
    int unsigned stuck;
    stuck = 0;
    wait (rst_ni);
    while (stuck < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) stuck = 0;
      else stuck++;
    end
    $display("no transfer for %0d cycles, %0d results still expected", stuck,
             board.outstanding());
    $display("status: fail");
    $finish;
  end

  initial begin
    int unsigned r;
    int unsigned dur;
    int unsigned polls;
    int unsigned seq_count;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_TICK;
    quiet         = 1'b0;
    n_live        = 0;
    n_starts      = 0;
    n_ticks       = 0;
    n_moves_done  = 0;
    seq_count     = 0;
    rst_ni        = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: idle ticks, zero duration, more steps than milliseconds, pulses
    // on the final poll, extreme field values, and a start while a move is running.
    send_item(OP_TICK, tick_noise());
    run_move('0, '1, 1'b1, '1, 1'b1, 1);
    run_move(16'd3, '1, 1'b1, '0, 1'b0, 4);
    run_move(16'd4, 16'd2, 1'b0, 16'd4, 1'b1, 6);
    run_move('1, 16'd1, 1'b1, '1, 1'b1, 3);
    run_move(16'd2, 16'd5, 1'b0, 16'd1, 1'b1, 3);
    run_move(16'd1, '0, 1'b1, 16'd1, 1'b0, 2);
    drain();

    quiet = 1'b1;
    while (n_live < LIVE_ITEMS) begin
      seq_count++;
      if ($urandom_range(0, 9) == 0) quiet = !quiet;
      // Every so often let the block run dry before the next move.
      if (seq_count % 40 == 0) drain();
      r = $urandom_range(0, 99);
      if (r < 5) begin
        send_item(OP_TICK, tick_noise());
      end else if (r < 10) begin
        run_move('0, STEP_BITS'($urandom), 1'($urandom), STEP_BITS'($urandom),
                 1'($urandom), $urandom_range(0, 2));
      end else begin
        r = $urandom_range(0, 99);
        if (r < 80) dur = $urandom_range(1, 24);
        else if (r < 92) dur = $urandom_range(25, 200);
        else dur = $urandom_range(1, 65535);
        if (dur > 200) polls = $urandom_range(0, 6);
        else if ($urandom_range(0, 3) != 0) polls = dur + 1 + $urandom_range(0, 2);
        else polls = $urandom_range(0, dur);
        run_move(TIME_BITS'(dur), pick_steps(dur), 1'($urandom), pick_steps(dur),
                 1'($urandom), polls);
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("sent %0d starts and %0d ticks, %0d moves ended, %0d results checked",
             n_starts, n_ticks, n_moves_done, board.checked);
    $display("%0d mismatches, %0d results still expected", board.mismatches,
             board.outstanding());
    if (board.mismatches == 0 && board.outstanding() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tspt_pkg.sv
rtl/tspt_div.sv
rtl/tspt_axis.sv
rtl/two_axis_step_pulse_timer_core.sv
dv/tb_two_axis_step_pulse_timer_core.sv
